// ----- rtl/pel_pkg.sv -----
// ============================================================================
// pel_pkg - shared types and constants for the polynomial easing unit
// Curve codes, the curve family decoded from them and the control group
// that travels down the pipeline beside the data.
// ============================================================================
`default_nettype none

package pel_pkg;

  // width of the curve selector
  localparam int CURVE_W = 4;

  // curve codes
  localparam logic [CURVE_W-1:0] CURVE_START_LAST = 4'd4;   // t^2 .. t^6
  localparam logic [CURVE_W-1:0] CURVE_STOP_FIRST = 4'd5;   // 1-(1-t)^2 ..
  localparam logic [CURVE_W-1:0] CURVE_STOP_LAST  = 4'd9;   // .. 1-(1-t)^6
  localparam logic [CURVE_W-1:0] CURVE_SS3        = 4'd10;  // smoothstep cubic
  localparam logic [CURVE_W-1:0] CURVE_SS5        = 4'd11;  // smootherstep
  localparam logic [CURVE_W-1:0] CURVE_HES3       = 4'd12;  // hesitate cubic
  localparam logic [CURVE_W-1:0] CURVE_HES5       = 4'd13;  // hesitate quintic

  // number of shared multiply stages (highest power is t^6)
  localparam int NUM_MUL_STAGES = 5;
  localparam int CNT_W = 3;

  // curve family, decides the operand of the last multiply and the finish
  typedef enum logic [2:0] {
    KIND_START,
    KIND_STOP,
    KIND_SS3,
    KIND_SS5,
    KIND_HES_UP,
    KIND_HES_DN,
    KIND_BAD
  } kind_t;

  // control group travelling with each item
  typedef struct packed {
    kind_t            kind;
    logic [CNT_W-1:0] cnt;   // multiplies still to do
  } ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/pel_in_if.sv -----
// ============================================================================
// pel_in_if - input item channel of the polynomial easing unit
// Valid/ready handshake carrying the curve code and the parameter t.
// ============================================================================
`default_nettype none

interface pel_in_if #(
  parameter int FRAC_BITS = 16
) ();
  import pel_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CURVE_W-1:0]   curve;
  logic [FRAC_BITS:0]   t_value;

  modport source (output valid, output curve, output t_value, input ready);
  modport sink   (input valid, input curve, input t_value, output ready);
endinterface

`default_nettype wire

// ----- rtl/pel_out_if.sv -----
// ============================================================================
// pel_out_if - result item channel of the polynomial easing unit
// Valid/ready handshake carrying the eased value and the bad curve flag.
// ============================================================================
`default_nettype none

interface pel_out_if #(
  parameter int FRAC_BITS = 16
) ();
  logic               valid;
  logic               ready;
  logic [FRAC_BITS:0] eased;
  logic               bad_curve;

  modport source (output valid, output eased, output bad_curve, input ready);
  modport sink   (input valid, input eased, input bad_curve, output ready);
endinterface

`default_nettype wire

// ----- rtl/pel_prep.sv -----
// ============================================================================
// pel_prep - front two pipeline stages
// Stage A clamps t, decodes the curve and forms the power base and the
// linear factor. Stage B folds the inner product of the quintic smoothstep.
// ============================================================================
`default_nettype none

module pel_prep #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         up_valid,
  output logic                              up_ready,
  input  wire logic [pel_pkg::CURVE_W-1:0]  up_curve,
  input  wire logic [FRAC_BITS:0]           up_t,
  output logic                              dn_valid,
  input  wire logic                         dn_ready,
  output pel_pkg::ctrl_t                    dn_ctrl,
  output logic [FRAC_BITS:0]                dn_x,
  output logic [FRAC_BITS+3:0]              dn_aux
);
  import pel_pkg::*;

  localparam int XW = FRAC_BITS + 1;
  localparam int AW = FRAC_BITS + 4;
  localparam int MW = XW + AW;
  localparam logic [XW-1:0] ONE         = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [AW-1:0] THREE_ONE   = AW'(3) << FRAC_BITS;
  localparam logic [AW-1:0] TEN_ONE     = AW'(10) << FRAC_BITS;
  localparam logic [AW-1:0] FIFTEEN_ONE = AW'(15) << FRAC_BITS;
  localparam logic [MW-1:0] HALF_LSB    = MW'(1) << (FRAC_BITS - 1);

  // stage A registers
  logic            a_vld_r;
  ctrl_t           a_ctrl_r, a_ctrl_nxt;
  logic [XW-1:0]   a_t_r, a_x_r, a_x_nxt;
  logic [AW-1:0]   a_aux_r, a_aux_nxt;
  logic            a_ready;

  // stage B registers
  logic            b_vld_r;
  ctrl_t           b_ctrl_r;
  logic [XW-1:0]   b_x_r;
  logic [AW-1:0]   b_aux_r, b_aux_nxt;

  logic [XW-1:0]   t_clamp;
  logic [XW:0]     t_twice;
  logic            hes_up;
  logic [AW-1:0]   t_wide;
  logic [MW-1:0]   inner_prod;
  logic [AW-1:0]   inner_mul;

  // handshake: a stage loads when empty or when it is being drained
  assign a_ready  = !b_vld_r || dn_ready;
  assign up_ready = !a_vld_r || a_ready;

  // clamp t and decode the curve
  always_comb begin
    t_clamp = (up_t > ONE) ? ONE : up_t;
    t_twice = {t_clamp, 1'b0};
    hes_up  = (t_twice >= (XW+1)'(ONE));
    t_wide  = AW'(t_clamp);

    a_ctrl_nxt.kind = KIND_BAD;
    a_ctrl_nxt.cnt  = '0;
    a_x_nxt         = t_clamp;
    a_aux_nxt       = '0;

    case (up_curve)
      CURVE_SS3: begin
        a_ctrl_nxt.kind = KIND_SS3;
        a_ctrl_nxt.cnt  = CNT_W'(2);
        a_aux_nxt       = THREE_ONE - (t_wide << 1);
      end
      CURVE_SS5: begin
        a_ctrl_nxt.kind = KIND_SS5;
        a_ctrl_nxt.cnt  = CNT_W'(3);
        a_aux_nxt       = FIFTEEN_ONE - ((t_wide << 2) + (t_wide << 1));
      end
      CURVE_HES3, CURVE_HES5: begin
        a_ctrl_nxt.kind = hes_up ? KIND_HES_UP : KIND_HES_DN;
        a_ctrl_nxt.cnt  = (up_curve == CURVE_HES3) ? CNT_W'(2) : CNT_W'(4);
        a_x_nxt         = hes_up ? XW'(t_twice - (XW+1)'(ONE))
                                 : XW'((XW+1)'(ONE) - t_twice);
      end
      default: begin
        if (up_curve <= CURVE_START_LAST) begin
          a_ctrl_nxt.kind = KIND_START;
          a_ctrl_nxt.cnt  = CNT_W'(up_curve + 4'd1);
        end else if (up_curve <= CURVE_STOP_LAST) begin
          a_ctrl_nxt.kind = KIND_STOP;
          a_ctrl_nxt.cnt  = CNT_W'(up_curve - CURVE_STOP_FIRST + 4'd1);
          a_x_nxt         = ONE - t_clamp;
        end
      end
    endcase
  end

  // stage A
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (up_ready) begin
      a_vld_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      a_ctrl_r <= a_ctrl_nxt;
      a_t_r    <= t_clamp;
      a_x_r    <= a_x_nxt;
      a_aux_r  <= a_aux_nxt;
    end
  end

  // inner term of the quintic smoothstep: 10 - t*(15 - 6t)
  always_comb begin
    inner_prod = MW'(a_t_r) * MW'(a_aux_r) + HALF_LSB;
    inner_mul  = inner_prod[FRAC_BITS +: AW];
    b_aux_nxt  = (a_ctrl_r.kind == KIND_SS5) ? (TEN_ONE - inner_mul) : a_aux_r;
  end

  // stage B
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (a_ready) begin
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && a_vld_r) begin
      b_ctrl_r <= a_ctrl_r;
      b_x_r    <= a_x_r;
      b_aux_r  <= b_aux_nxt;
    end
  end

  assign dn_valid = b_vld_r;
  assign dn_ctrl  = b_ctrl_r;
  assign dn_x     = b_x_r;
  assign dn_aux   = b_aux_r;

endmodule

`default_nettype wire

// ----- rtl/pel_mul_stage.sv -----
// ============================================================================
// pel_mul_stage - one rounded fixed-point multiply stage
// Multiplies the running product by the base, or by the linear factor on
// the last step of a smoothstep; passes the item on once its count is spent.
// ============================================================================
`default_nettype none

module pel_mul_stage #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              up_valid,
  output logic                   up_ready,
  input  wire pel_pkg::ctrl_t    up_ctrl,
  input  wire logic [FRAC_BITS:0]   up_x,
  input  wire logic [FRAC_BITS+3:0] up_aux,
  input  wire logic [FRAC_BITS+1:0] up_p,
  output logic                   dn_valid,
  input  wire logic              dn_ready,
  output pel_pkg::ctrl_t         dn_ctrl,
  output logic [FRAC_BITS:0]     dn_x,
  output logic [FRAC_BITS+3:0]   dn_aux,
  output logic [FRAC_BITS+1:0]   dn_p
);
  import pel_pkg::*;

  localparam int XW = FRAC_BITS + 1;
  localparam int AW = FRAC_BITS + 4;
  localparam int PW = FRAC_BITS + 2;
  localparam int MW = PW + AW;
  localparam logic [MW-1:0] HALF_LSB = MW'(1) << (FRAC_BITS - 1);

  logic            vld_r;
  ctrl_t           ctrl_r, ctrl_nxt;
  logic [XW-1:0]   x_r;
  logic [AW-1:0]   aux_r;
  logic [PW-1:0]   p_r, p_nxt;
  logic            use_aux;
  logic [AW-1:0]   operand;
  logic [MW-1:0]   prod;

  assign up_ready = !vld_r || dn_ready;

  // rounded multiply, half up
  always_comb begin
    use_aux  = ((up_ctrl.kind == KIND_SS3) || (up_ctrl.kind == KIND_SS5)) &&
               (up_ctrl.cnt == CNT_W'(1));
    operand  = use_aux ? up_aux : AW'(up_x);
    prod     = MW'(up_p) * MW'(operand) + HALF_LSB;
    ctrl_nxt = up_ctrl;
    p_nxt    = up_p;
    if (up_ctrl.cnt != '0) begin
      p_nxt        = prod[FRAC_BITS +: PW];
      ctrl_nxt.cnt = up_ctrl.cnt - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_ready) begin
      vld_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      ctrl_r <= ctrl_nxt;
      x_r    <= up_x;
      aux_r  <= up_aux;
      p_r    <= p_nxt;
    end
  end

  assign dn_valid = vld_r;
  assign dn_ctrl  = ctrl_r;
  assign dn_x     = x_r;
  assign dn_aux   = aux_r;
  assign dn_p     = p_r;

endmodule

`default_nettype wire

// ----- rtl/pel_finish.sv -----
// ============================================================================
// pel_finish - output stage
// Applies the smooth-stop and hesitate corrections, saturates to one and
// holds the result item in the output register.
// ============================================================================
`default_nettype none

module pel_finish #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 up_valid,
  output logic                      up_ready,
  input  wire pel_pkg::ctrl_t       up_ctrl,
  input  wire logic [FRAC_BITS+1:0] up_p,
  output logic                      dn_valid,
  input  wire logic                 dn_ready,
  output logic [FRAC_BITS:0]        dn_eased,
  output logic                      dn_bad
);
  import pel_pkg::*;

  localparam int XW = FRAC_BITS + 1;
  localparam int PW = FRAC_BITS + 2;
  localparam logic [PW-1:0] ONE_P = PW'(1) << FRAC_BITS;

  logic            vld_r;
  logic [XW-1:0]   eased_r, eased_nxt;
  logic            bad_r;
  logic [PW-1:0]   res;

  assign up_ready = !vld_r || dn_ready;

  // per-family finish and saturation
  always_comb begin
    case (up_ctrl.kind)
      KIND_START, KIND_SS3, KIND_SS5: res = up_p;
      KIND_STOP:   res = ONE_P - up_p;
      KIND_HES_UP: res = (ONE_P + up_p + PW'(1)) >> 1;
      KIND_HES_DN: res = (ONE_P - up_p + PW'(1)) >> 1;
      default:     res = '0;
    endcase
    eased_nxt = (res > ONE_P) ? XW'(ONE_P) : res[XW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_ready) begin
      vld_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      eased_r <= eased_nxt;
      bad_r   <= (up_ctrl.kind == KIND_BAD);
    end
  end

  assign dn_valid = vld_r;
  assign dn_eased = eased_r;
  assign dn_bad   = bad_r;

endmodule

`default_nettype wire

// ----- rtl/polynomial_easing_unit.sv -----
// ============================================================================
// polynomial_easing_unit - pipelined polynomial easing curves
// Smooth-start, smooth-stop, smoothstep and hesitate curves of t in
// unsigned Q1.FRAC_BITS, rounded half up and saturated to [0, 1].
// ============================================================================
//
//  channel   dir  handshake      payload
//  in_chan   in   valid/ready    curve[3:0], t_value[FRAC_BITS:0]
//  out_chan  out  valid/ready    eased[FRAC_BITS:0], bad_curve
//
//  One item is taken every cycle unless a stall on out_chan fills the pipeline.
//  Eight register stages: decode, smoothstep inner term, five shared multiply
//  stages for the powers up to t^6, and the output register.
//  Reset (rst_n low, synchronous) empties every stage; no state is kept.
//  A stall on out_chan holds the output register; upstream stages keep
//  filling empty slots, so in_chan.ready drops only once every stage is full.
//
`default_nettype none

module polynomial_easing_unit #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  pel_in_if.sink     in_chan,
  pel_out_if.source  out_chan
);
  import pel_pkg::*;

  localparam int XW = FRAC_BITS + 1;
  localparam int AW = FRAC_BITS + 4;
  localparam int PW = FRAC_BITS + 2;

  // pipeline links between the prep stage, the multiply stages and the finish
  logic [NUM_MUL_STAGES:0] lk_valid;
  logic [NUM_MUL_STAGES:0] lk_ready;
  ctrl_t                   lk_ctrl [0:NUM_MUL_STAGES];
  logic [XW-1:0]           lk_x    [0:NUM_MUL_STAGES];
  logic [AW-1:0]           lk_aux  [0:NUM_MUL_STAGES];
  logic [PW-1:0]           lk_p    [0:NUM_MUL_STAGES];

  // decode and smoothstep inner term
  pel_prep #(
    .FRAC_BITS (FRAC_BITS)
  ) u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_chan.valid),
    .up_ready (in_chan.ready),
    .up_curve (in_chan.curve),
    .up_t     (in_chan.t_value),
    .dn_valid (lk_valid[0]),
    .dn_ready (lk_ready[0]),
    .dn_ctrl  (lk_ctrl[0]),
    .dn_x     (lk_x[0]),
    .dn_aux   (lk_aux[0])
  );

  // the running product starts at the base
  assign lk_p[0] = PW'(lk_x[0]);

  // shared multiply stages
  for (genvar i = 0; i < NUM_MUL_STAGES; i++) begin : g_mul
    pel_mul_stage #(
      .FRAC_BITS (FRAC_BITS)
    ) u_mul (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (lk_valid[i]),
      .up_ready (lk_ready[i]),
      .up_ctrl  (lk_ctrl[i]),
      .up_x     (lk_x[i]),
      .up_aux   (lk_aux[i]),
      .up_p     (lk_p[i]),
      .dn_valid (lk_valid[i+1]),
      .dn_ready (lk_ready[i+1]),
      .dn_ctrl  (lk_ctrl[i+1]),
      .dn_x     (lk_x[i+1]),
      .dn_aux   (lk_aux[i+1]),
      .dn_p     (lk_p[i+1])
    );
  end

  // finish and output register
  pel_finish #(
    .FRAC_BITS (FRAC_BITS)
  ) u_finish (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (lk_valid[NUM_MUL_STAGES]),
    .up_ready (lk_ready[NUM_MUL_STAGES]),
    .up_ctrl  (lk_ctrl[NUM_MUL_STAGES]),
    .up_p     (lk_p[NUM_MUL_STAGES]),
    .dn_valid (out_chan.valid),
    .dn_ready (out_chan.ready),
    .dn_eased (out_chan.eased),
    .dn_bad   (out_chan.bad_curve)
  );

`ifndef SYNTH
  // an invalid curve always reports zero
  a_bad_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.bad_curve |-> out_chan.eased == '0)
    else $error("bad curve item with non-zero eased value");

  // results never exceed one
  a_saturated: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> out_chan.eased <= XW'(1) << FRAC_BITS)
    else $error("eased value above one");

  // back-pressure only when the whole pipe is full and the output stalls
  a_ready_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_chan.ready |-> out_chan.valid && !out_chan.ready && (&lk_valid))
    else $error("input stalled with room in the pipeline");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_chan.valid && !(|lk_valid))
    else $error("item left in the pipeline after reset");
`endif

endmodule

`default_nettype wire
